/* design/spmm_pkg.sv */
`timescale 1ns / 1ps

package spmm_pkg;

    localparam logic [1:0] FN_LOAD_A = 2'd0;
    localparam logic [1:0] FN_LOAD_B = 2'd1;
    localparam logic [1:0] FN_RUN    = 2'd2;

    localparam logic [1:0] REG_ROWS  = 2'd0;
    localparam logic [1:0] REG_COLS  = 2'd1;
    localparam logic [1:0] REG_DEPTH = 2'd2;

    localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } state_t;

    // one multiply-add per cell takes one pass through these phases
    typedef enum logic [2:0] {
        PH_MUL,
        PH_MLZ,
        PH_MNORM,
        PH_MRND,
        PH_ADD,
        PH_ALZ,
        PH_ANORM,
        PH_ARND
    } phase_t;

    typedef struct packed {
        logic   run;
        phase_t phase;
    } cell_ctrl_t;

    // unrounded operation result: value = w * 2^(bb - 127 - 47), leading one anywhere
    typedef struct packed {
        logic               spec;
        logic [31:0]        specv;
        logic               sgn;
        logic [47:0]        w;
        logic signed [10:0] bb;
    } front_t;

    function automatic logic [5:0] lzc48(input logic [47:0] w);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 48; i++)
        begin
            if (w[i])
            begin
                n = 6'(47 - i);
            end
        end
        return n;
    endfunction

    function automatic front_t fp_mul_front(input logic [31:0] a, input logic [31:0] b);
        front_t     f;
        logic       na, nb, ia, ib, za, zb, s;
        logic [7:0] ea, eb;
        logic [23:0] ma, mb;
        f  = '0;
        s  = a[31] ^ b[31];
        na = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nb = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        ia = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        ib = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        za = (a[30:0] == 31'd0);
        zb = (b[30:0] == 31'd0);
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        if (na || nb || (ia && zb) || (za && ib))
        begin
            f.spec  = 1'b1;
            f.specv = FP_QNAN;
        end
        else if (ia || ib)
        begin
            f.spec  = 1'b1;
            f.specv = {s, 8'hFF, 23'd0};
        end
        else if (za || zb)
        begin
            f.spec  = 1'b1;
            f.specv = {s, 31'd0};
        end
        else
        begin
            f.sgn = s;
            f.w   = {24'd0, ma} * {24'd0, mb};
            f.bb  = $signed(11'(ea) + 11'(eb) - 11'd126);
        end
        return f;
    endfunction

    function automatic front_t fp_add_front(input logic [31:0] x, input logic [31:0] y);
        front_t      f;
        logic        nx, ny, ix, iy, swap, stk;
        logic [31:0] big, sml;
        logic [7:0]  eb, es, d;
        logic [23:0] mb, ms;
        logic [26:0] mb3, ms3, sh3, mask;
        logic [27:0] sum;
        f    = '0;
        nx   = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
        ny   = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
        ix   = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
        iy   = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
        swap = y[30:0] > x[30:0];
        big  = swap ? y : x;
        sml  = swap ? x : y;
        eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        mb   = {big[30:23] != 8'd0, big[22:0]};
        ms   = {sml[30:23] != 8'd0, sml[22:0]};
        d    = eb - es;
        mb3  = {mb, 3'b000};
        ms3  = {ms, 3'b000};
        if (d >= 8'd27)
        begin
            sh3 = 27'd0;
            stk = (ms3 != 27'd0);
        end
        else
        begin
            mask = (27'd1 << d) - 27'd1;
            sh3  = ms3 >> d;
            stk  = ((ms3 & mask) != 27'd0);
        end
        sh3[0] = sh3[0] | stk;
        if (big[31] ^ sml[31])
        begin
            sum = {1'b0, mb3} - {1'b0, sh3};
        end
        else
        begin
            sum = {1'b0, mb3} + {1'b0, sh3};
        end
        if (nx || ny || (ix && iy && (x[31] != y[31])))
        begin
            f.spec  = 1'b1;
            f.specv = FP_QNAN;
        end
        else if (ix)
        begin
            f.spec  = 1'b1;
            f.specv = x;
        end
        else if (iy)
        begin
            f.spec  = 1'b1;
            f.specv = y;
        end
        else if (sum == 28'd0)
        begin
            f.spec  = 1'b1;
            f.specv = {x[31] & y[31], 31'd0};
        end
        else
        begin
            f.sgn = big[31];
            f.w   = {sum, 20'd0};
            f.bb  = $signed(11'(eb) + 11'd1);
        end
        return f;
    endfunction

    // w has its leading one at bit 47, be is the biased exponent of that bit
    function automatic logic [31:0] fp_round(input logic s, input logic [47:0] w,
                                             input logic signed [10:0] be);
        logic [5:0]         sh;
        logic signed [10:0] shw;
        logic [47:0]        v, mask;
        logic               stk, g, inc;
        logic [7:0]         exf;
        logic [30:0]        base;
        logic [31:0]        res;
        shw = 11'sd1 - be;
        if (be >= 11'sd1)
        begin
            sh  = 6'd0;
            exf = be[7:0];
        end
        else
        begin
            sh  = (shw > 11'sd63) ? 6'd63 : shw[5:0];
            exf = 8'd0;
        end
        v    = w >> sh;
        mask = (sh >= 6'd48) ? '1 : ((48'd1 << sh) - 48'd1);
        stk  = ((w & mask) != 48'd0) || (v[22:0] != 23'd0);
        g    = v[23];
        inc  = g & (stk | v[24]);
        base = {exf, v[46:24]};
        if (be >= 11'sd255)
        begin
            res = {s, 8'hFF, 23'd0};
        end
        else
        begin
            res = {s, base + 31'(inc)};
        end
        return res;
    endfunction

endpackage

/* design/spmm_in_if.sv */
`timescale 1ns / 1ps

interface spmm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [3:0]  row_index;
    logic [3:0]  col_index;
    logic [31:0] element_bits;

    modport source (output valid, output func, output row_index, output col_index,
                    output element_bits, input ready);
    modport sink (input valid, input func, input row_index, input col_index,
                  input element_bits, output ready);
endinterface

/* design/spmm_out_if.sv */
`timescale 1ns / 1ps

interface spmm_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  out_row;
    logic [2:0]  out_col;
    logic [31:0] result_bits;
    logic        last;

    modport source (output valid, output out_row, output out_col, output result_bits,
                    output last, input ready);
    modport sink (input valid, input out_row, input out_col, input result_bits,
                  input last, output ready);
endinterface

/* design/spmm_cfg_if.sv */
`timescale 1ns / 1ps

interface spmm_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [4:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* design/spmm_ram.sv */
`timescale 1ns / 1ps

module spmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/spmm_cell.sv */
`timescale 1ns / 1ps

module spmm_cell
    import spmm_pkg::*;
#(
    parameter int MAX_K = 16,
    parameter int KW    = (MAX_K > 1) ? $clog2(MAX_K) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cell_ctrl_t    ctrl,
    input  logic          b_we,
    input  logic [KW-1:0] b_waddr,
    input  logic [31:0]   b_wdata,
    input  logic [31:0]   a_in,
    input  logic [KW-1:0] k_in,
    input  logic          v_in,
    output logic [31:0]   a_out,
    output logic [KW-1:0] k_out,
    output logic          v_out,
    output logic [31:0]   acc
);

    logic [31:0]        a_reg, prod_reg, prod_next, acc_reg, acc_next, b_rdata;
    logic [KW-1:0]      k_reg;
    logic               v_reg;
    logic               shift;
    logic [47:0]        w_reg, w_next;
    logic signed [10:0] bb_reg, bb_next;
    logic               sgn_reg, sgn_next, spec_reg, spec_next;
    logic [31:0]        specv_reg, specv_next, rnd;
    logic [5:0]         lz_reg, lz_next;
    front_t             fr;

    // column of B held by this cell; read address leads by one step
    spmm_ram #(.WIDTH(32), .DEPTH(MAX_K), .AW(KW)) u_bmem (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (k_in),
        .rdata (b_rdata)
    );

    assign shift = ctrl.run && (ctrl.phase == PH_ARND);
    assign rnd   = spec_reg ? specv_reg : fp_round(sgn_reg, w_reg, bb_reg);

    always_comb
    begin
        fr         = '0;
        w_next     = w_reg;
        bb_next    = bb_reg;
        sgn_next   = sgn_reg;
        spec_next  = spec_reg;
        specv_next = specv_reg;
        lz_next    = lz_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        if (ctrl.run && v_reg)
        begin
            unique case (ctrl.phase)
                PH_MUL, PH_ADD:
                begin
                    if (ctrl.phase == PH_MUL)
                    begin
                        fr = fp_mul_front(a_reg, b_rdata);
                    end
                    else
                    begin
                        fr = fp_add_front((k_reg == '0) ? 32'd0 : acc_reg, prod_reg);
                    end
                    w_next     = fr.w;
                    bb_next    = fr.bb;
                    sgn_next   = fr.sgn;
                    spec_next  = fr.spec;
                    specv_next = fr.specv;
                end
                PH_MLZ, PH_ALZ:
                begin
                    lz_next = lzc48(w_reg);
                end
                PH_MNORM, PH_ANORM:
                begin
                    w_next  = w_reg << lz_reg;
                    bb_next = bb_reg - $signed({5'd0, lz_reg});
                end
                PH_MRND:
                begin
                    prod_next = rnd;
                end
                PH_ARND:
                begin
                    acc_next = rnd;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (shift)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            a_reg <= a_in;
            k_reg <= k_in;
        end
        w_reg     <= w_next;
        bb_reg    <= bb_next;
        sgn_reg   <= sgn_next;
        spec_reg  <= spec_next;
        specv_reg <= specv_next;
        lz_reg    <= lz_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
    end

    assign a_out = a_reg;
    assign k_out = k_reg;
    assign v_out = v_reg;
    assign acc   = acc_reg;

endmodule

/* design/single_precision_matrix_multiply.sv */
`timescale 1ns / 1ps
// Load items are accepted whenever the block is idle. A compute item runs rows_m row passes;
// each pass steps the cell chain through depth_k + cols_n multiply-add steps (each step one
// pass through the phases of the shared per-cell float unit, A skewed one step per cell),
// then emits its cols_n results, one result per cycle when the output is not stalled.
// Reset (rst_n low, asynchronous) clears control and restores rows_m 8, cols_n 8,
// depth_k 16; A and B stores are undefined until written, no clearing pass.

module single_precision_matrix_multiply
    import spmm_pkg::*;
#(
    parameter int MAX_M = 8,
    parameter int MAX_N = 8,
    parameter int MAX_K = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    spmm_in_if.sink     in_ch,
    spmm_out_if.source  out_ch,
    spmm_cfg_if.sink    cfg
);

    localparam int KW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int RW = (MAX_M > 1) ? $clog2(MAX_M) : 1;
    localparam int CW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int MW = $clog2(MAX_M + 1);
    localparam int NW = $clog2(MAX_N + 1);
    localparam int DW = $clog2(MAX_K + 1);
    localparam int SW = $clog2(MAX_K + MAX_N + 1);
    localparam int AW = (MAX_M * MAX_K > 1) ? $clog2(MAX_M * MAX_K) : 1;

    state_t         state_reg, state_next;
    phase_t         phase_reg, phase_next;
    logic [SW-1:0]  step_reg, step_next, step_last;
    logic [RW-1:0]  row_reg, row_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [MW-1:0]  rows_reg;
    logic [NW-1:0]  cols_reg;
    logic [DW-1:0]  depth_reg;
    logic           out_valid_reg, out_valid_next;
    logic [2:0]     out_row_reg, out_col_reg;
    logic [31:0]    out_data_reg;
    logic           out_last_reg;
    logic           in_acc, load_a, load_b, start, step_end, out_load, col_done, row_done;
    logic [31:0]    a_rdata;
    logic [AW-1:0]  a_raddr, a_waddr;
    logic [KW-1:0]  feed_k;
    logic           feed_v;
    cell_ctrl_t     ctrl;

    logic [31:0]    a_ch [MAX_N];
    logic [KW-1:0]  k_ch [MAX_N];
    logic           v_ch [MAX_N];
    logic [31:0]    acc_w [MAX_N];

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= MW'(MAX_M);
            cols_reg  <= NW'(MAX_N);
            depth_reg <= DW'(MAX_K);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ROWS:
                begin
                    if (cfg.data[3:0] == 4'd0)
                        rows_reg <= MW'(1);
                    else if (32'(cfg.data[3:0]) > MAX_M)
                        rows_reg <= MW'(MAX_M);
                    else
                        rows_reg <= MW'(cfg.data[3:0]);
                end
                REG_COLS:
                begin
                    if (cfg.data[3:0] == 4'd0)
                        cols_reg <= NW'(1);
                    else if (32'(cfg.data[3:0]) > MAX_N)
                        cols_reg <= NW'(MAX_N);
                    else
                        cols_reg <= NW'(cfg.data[3:0]);
                end
                REG_DEPTH:
                begin
                    if (cfg.data == 5'd0)
                        depth_reg <= DW'(1);
                    else if (32'(cfg.data) > MAX_K)
                        depth_reg <= DW'(MAX_K);
                    else
                        depth_reg <= DW'(cfg.data);
                end
                default:
                begin
                end
            endcase
        end
    end

    // request decode
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign load_a      = in_acc && (in_ch.func == FN_LOAD_A)
                         && (32'(in_ch.row_index) < MAX_M) && (32'(in_ch.col_index) < MAX_K);
    assign load_b      = in_acc && (in_ch.func == FN_LOAD_B)
                         && (32'(in_ch.row_index) < MAX_K) && (32'(in_ch.col_index) < MAX_N);
    assign start       = in_acc && (in_ch.func == FN_RUN);

    // A store
    assign feed_k  = KW'(step_reg);
    assign feed_v  = (32'(step_reg) < 32'(depth_reg));
    assign a_raddr = AW'(32'(row_reg) * MAX_K + 32'(feed_k));
    assign a_waddr = AW'(32'(in_ch.row_index) * MAX_K + 32'(in_ch.col_index));

    spmm_ram #(.WIDTH(32), .DEPTH(MAX_M * MAX_K), .AW(AW)) u_amem (
        .clk   (clk),
        .we    (load_a),
        .waddr (a_waddr),
        .wdata (in_ch.element_bits),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    // cell chain, one cell per column of C
    assign ctrl.run   = (state_reg == ST_RUN);
    assign ctrl.phase = phase_reg;

    for (genvar c = 0; c < MAX_N; c++)
    begin : g_cell
        logic [31:0]   a_i;
        logic [KW-1:0] k_i;
        logic          v_i;
        if (c == 0)
        begin : g_head
            assign a_i = a_rdata;
            assign k_i = feed_k;
            assign v_i = feed_v;
        end
        else
        begin : g_link
            assign a_i = a_ch[c-1];
            assign k_i = k_ch[c-1];
            assign v_i = v_ch[c-1];
        end
        spmm_cell #(.MAX_K(MAX_K), .KW(KW)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .b_we    (load_b && (32'(in_ch.col_index) == c)),
            .b_waddr (KW'(in_ch.row_index)),
            .b_wdata (in_ch.element_bits),
            .a_in    (a_i),
            .k_in    (k_i),
            .v_in    (v_i),
            .a_out   (a_ch[c]),
            .k_out   (k_ch[c]),
            .v_out   (v_ch[c]),
            .acc     (acc_w[c])
        );
    end

    // sequencer
    assign step_last = SW'(depth_reg) + SW'(cols_reg) - SW'(1);
    assign step_end  = (phase_reg == PH_ARND) && (step_reg == step_last);
    assign out_load  = (state_reg == ST_EMIT) && (!out_valid_reg || out_ch.ready);
    assign col_done  = ((NW'(col_reg) + NW'(1)) == cols_reg);
    assign row_done  = ((MW'(row_reg) + MW'(1)) == rows_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (step_end)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_load && col_done)
                    state_next = row_done ? ST_IDLE : ST_RUN;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        step_next      = step_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg;
        if (out_ch.ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                phase_next = PH_MUL;
                step_next  = '0;
                row_next   = '0;
                col_next   = '0;
            end
            ST_RUN:
            begin
                phase_next = phase_t'(3'(phase_reg + 3'd1));
                if (phase_reg == PH_ARND)
                    step_next = step_reg + SW'(1);
                col_next = '0;
            end
            ST_EMIT:
            begin
                phase_next = PH_MUL;
                step_next  = '0;
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    col_next       = col_reg + CW'(1);
                    if (col_done)
                        row_next = row_reg + RW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_MUL;
            step_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg  <= 3'(row_reg);
            out_col_reg  <= 3'(col_reg);
            out_data_reg <= acc_w[col_reg];
            out_last_reg <= col_done && row_done;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_row     = out_row_reg;
    assign out_ch.out_col     = out_col_reg;
    assign out_ch.result_bits = out_data_reg;
    assign out_ch.last        = out_last_reg;

endmodule

/* bench/single_precision_matrix_multiply_tb.sv */
`timescale 1ns / 1ps

module single_precision_matrix_multiply_tb;
    import spmm_pkg::*;

    localparam int ROWS_MAX  = 8;
    localparam int COLS_MAX  = 8;
    localparam int DEPTH_MAX = 16;
    localparam logic [1:0] FN_NONE  = 2'd3;
    localparam logic [1:0] REG_NONE = 2'd3;

    typedef struct {
        logic [1:0]  func;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] bits;
    } mm_req_t;

    typedef struct {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] bits;
        logic        last;
    } c_elem_t;

    logic clk;
    logic rst_n;

    spmm_in_if  in_ch();
    spmm_out_if out_ch();
    spmm_cfg_if cfg();

    single_precision_matrix_multiply DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    mm_req_t     pending_reqs[$];
    c_elem_t     c_expected[$];
    logic [31:0] mat_a[0:ROWS_MAX*DEPTH_MAX-1];
    logic [31:0] mat_b[0:DEPTH_MAX*COLS_MAX-1];
    bit          a_seen[0:ROWS_MAX*DEPTH_MAX-1];
    bit          b_seen[0:DEPTH_MAX*COLS_MAX-1];
    int          dim_m;
    int          dim_n;
    int          dim_k;
    int          errors;
    int          send_gap;
    int          recv_gap;
    int          hold_cnt;
    bit          hold_go;
    bit          quiet;
    bit          in_took;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic int clamp_dim(int v, int maxv);
        if (v == 0)
        begin
            return 1;
        end
        if (v > maxv)
        begin
            return maxv;
        end
        return v;
    endfunction

    function automatic real f32_to_real(logic [31:0] x);
        real r;
        if (x[30:23] == 8'hFF)
        begin
            if (x[22:0] != 23'd0)
            begin
                return $bitstoreal(64'h7FF8_0000_0000_0000);
            end
            return $bitstoreal({x[31], 11'h7FF, 52'd0});
        end
        if (x[30:23] == 8'd0)
        begin
            r = real'(x[22:0]) * (2.0 ** (-149));
            return x[31] ? -r : r;
        end
        return $bitstoreal({x[31], 11'(x[30:23]) + 11'd896, x[22:0], 29'd0});
    endfunction

    // exact double to single, round to nearest even
    function automatic logic [31:0] real_to_f32(real r);
        logic [63:0] d;
        logic [63:0] mm;
        logic [63:0] q;
        logic [30:0] base;
        logic        s;
        logic        g;
        logic        st;
        int          e;
        int          drop;
        d  = $realtobits(r);
        s  = d[63];
        e  = int'(d[62:52]);
        mm = {11'd0, 1'b1, d[51:0]};
        if (e == 2047)
        begin
            return (d[51:0] != 52'd0) ? FP_QNAN : {s, 8'hFF, 23'd0};
        end
        if (e == 0)
        begin
            return {s, 31'd0};
        end
        e = e - 1023;
        if (e > 127)
        begin
            return {s, 8'hFF, 23'd0};
        end
        if (e >= -126)
        begin
            base = {8'(e + 127), mm[51:29]};
            g    = mm[28];
            st   = (mm[27:0] != 28'd0);
            return {s, base + 31'(g & (st | mm[29]))};
        end
        drop = -e - 97;
        if (drop >= 55)
        begin
            return {s, 31'd0};
        end
        q  = mm >> drop;
        g  = mm[drop-1];
        st = ((mm & ((64'd1 << (drop - 1)) - 64'd1)) != 64'd0);
        return {s, 31'(q) + 31'(g & (st | q[0]))};
    endfunction

    function automatic logic [31:0] mul_add(logic [31:0] acc, logic [31:0] a, logic [31:0] b);
        logic [31:0] prod;
        prod = real_to_f32(f32_to_real(a) * f32_to_real(b));
        return real_to_f32(f32_to_real(acc) + f32_to_real(prod));
    endfunction

    task automatic predict_product();
        c_elem_t     e;
        logic [31:0] acc;
        for (int r = 0; r < dim_m; r++)
        begin
            for (int c = 0; c < dim_n; c++)
            begin
                acc = 32'd0;
                for (int k = 0; k < dim_k; k++)
                begin
                    acc = mul_add(acc, mat_a[r*DEPTH_MAX+k], mat_b[k*COLS_MAX+c]);
                end
                if (acc[30:23] == 8'hFF && acc[22:0] != 23'd0)
                begin
                    acc = FP_QNAN;
                end
                e.row  = 3'(r);
                e.col  = 3'(c);
                e.bits = acc;
                e.last = (r == dim_m - 1) && (c == dim_n - 1);
                c_expected.push_back(e);
            end
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_ch.valid || in_took))
        begin
            in_took = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                send_gap = $urandom_range(1, 18) - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                in_ch.valid        <= 1'b1;
                in_ch.func         <= pending_reqs[0].func;
                in_ch.row_index    <= pending_reqs[0].row;
                in_ch.col_index    <= pending_reqs[0].col;
                in_ch.element_bits <= pending_reqs[0].bits;
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver stall control
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cnt > 0)
            begin
                out_ch.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                recv_gap = $urandom_range(1, 18) - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_go)
        begin
            hold_go  = 1'b0;
            hold_cnt = 400;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt--;
        end
    end

    // request acceptance and result check
    always @(posedge clk)
    begin
        mm_req_t q;
        c_elem_t w;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            q       = pending_reqs.pop_front();
            in_took = 1'b1;
            case (q.func)
                FN_LOAD_A:
                begin
                    if (q.row < ROWS_MAX && q.col < DEPTH_MAX)
                    begin
                        mat_a[q.row*DEPTH_MAX+q.col] = q.bits;
                    end
                end
                FN_LOAD_B:
                begin
                    if (q.row < DEPTH_MAX && q.col < COLS_MAX)
                    begin
                        mat_b[q.row*COLS_MAX+q.col] = q.bits;
                    end
                end
                FN_RUN:
                begin
                    predict_product();
                end
                default:
                begin
                end
            endcase
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (c_expected.size() == 0)
            begin
                report("unexpected result", out_ch.result_bits, 32'd0);
            end
            else
            begin
                w = c_expected.pop_front();
                if (out_ch.out_row !== w.row)
                begin
                    report("out_row", 32'(out_ch.out_row), 32'(w.row));
                end
                if (out_ch.out_col !== w.col)
                begin
                    report("out_col", 32'(out_ch.out_col), 32'(w.col));
                end
                if (out_ch.result_bits !== w.bits)
                begin
                    report("result_bits", out_ch.result_bits, w.bits);
                end
                if (out_ch.last !== w.last)
                begin
                    report("last", 32'(out_ch.last), 32'(w.last));
                end
            end
        end
    end

    task automatic push_req(logic [1:0] func, logic [3:0] row, logic [3:0] col,
                            logic [31:0] bits);
        mm_req_t q;
        q.func = func;
        q.row  = row;
        q.col  = col;
        q.bits = bits;
        if (func == FN_LOAD_A && row < ROWS_MAX && col < DEPTH_MAX)
        begin
            a_seen[row*DEPTH_MAX+col] = 1'b1;
        end
        if (func == FN_LOAD_B && row < DEPTH_MAX && col < COLS_MAX)
        begin
            b_seen[row*COLS_MAX+col] = 1'b1;
        end
        pending_reqs.push_back(q);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_ROWS:  dim_m = clamp_dim(int'(val[3:0]), ROWS_MAX);
            REG_COLS:  dim_n = clamp_dim(int'(val[3:0]), COLS_MAX);
            REG_DEPTH: dim_k = clamp_dim(int'(val), DEPTH_MAX);
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || c_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_elem();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v = v;
            1: v = {v[31], 8'd0, v[22:0]};
            2: v = {v[31], 8'hFF, (v[1] ? v[22:0] : 23'd0)};
            3: v = {v[31], 31'd0};
            4: v = {v[31], 8'hFE, v[22:0]};
            default: v = {v[31], 8'($urandom_range(117, 137)), v[22:0]};
        endcase
        return v;
    endfunction

    task automatic run_phase(int m_raw, int n_raw, int k_raw, int rounds, bit squeeze);
        write_reg(REG_ROWS, 5'(m_raw));
        write_reg(REG_COLS, 5'(n_raw));
        write_reg(REG_DEPTH, 5'(k_raw));
        if (squeeze)
        begin
            hold_go = 1'b1;
        end
        for (int n = 0; n < rounds; n++)
        begin
            repeat ($urandom_range(0, 6))
            begin
                case ($urandom_range(0, 9))
                    0: push_req(FN_LOAD_A, 4'($urandom), 4'($urandom), rand_elem());
                    1: push_req(FN_LOAD_B, 4'($urandom), 4'($urandom), rand_elem());
                    2: push_req(FN_NONE, 4'($urandom), 4'($urandom), $urandom);
                    3, 4, 5: push_req(FN_LOAD_A, 4'($urandom_range(0, dim_m - 1)),
                                      4'($urandom_range(0, dim_k - 1)), rand_elem());
                    default: push_req(FN_LOAD_B, 4'($urandom_range(0, dim_k - 1)),
                                      4'($urandom_range(0, dim_n - 1)), rand_elem());
                endcase
            end
            for (int r = 0; r < dim_m; r++)
            begin
                for (int k = 0; k < dim_k; k++)
                begin
                    if (!a_seen[r*DEPTH_MAX+k])
                    begin
                        push_req(FN_LOAD_A, 4'(r), 4'(k), rand_elem());
                    end
                end
            end
            for (int k = 0; k < dim_k; k++)
            begin
                for (int c = 0; c < dim_n; c++)
                begin
                    if (!b_seen[k*COLS_MAX+c])
                    begin
                        push_req(FN_LOAD_B, 4'(k), 4'(c), rand_elem());
                    end
                end
            end
            push_req(FN_RUN, 4'($urandom), 4'($urandom), $urandom);
        end
        drain();
    endtask

    initial
    begin
        errors             = 0;
        send_gap           = 0;
        recv_gap           = 0;
        hold_cnt           = 0;
        hold_go            = 1'b0;
        quiet              = 1'b0;
        in_took            = 1'b0;
        dim_m              = ROWS_MAX;
        dim_n              = COLS_MAX;
        dim_k              = DEPTH_MAX;
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.func         = FN_LOAD_A;
        in_ch.row_index    = 4'd0;
        in_ch.col_index    = 4'd0;
        in_ch.element_bits = 32'd0;
        out_ch.ready       = 1'b0;
        cfg.valid          = 1'b0;
        cfg.index          = REG_ROWS;
        cfg.data           = 5'd0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(REG_ROWS, 5'd2);
        write_reg(REG_COLS, 5'd2);
        write_reg(REG_DEPTH, 5'd3);
        write_reg(REG_NONE, 5'h1F);
        push_req(FN_LOAD_A, 4'd0, 4'd0, 32'h3F80_0000);
        push_req(FN_LOAD_A, 4'd0, 4'd1, 32'h7F7F_FFFF);
        push_req(FN_LOAD_A, 4'd0, 4'd2, 32'h8000_0000);
        push_req(FN_LOAD_A, 4'd1, 4'd0, 32'h0000_0001);
        push_req(FN_LOAD_A, 4'd1, 4'd1, 32'h7F80_0000);
        push_req(FN_LOAD_A, 4'd1, 4'd2, 32'hFFFF_FFFF);
        push_req(FN_LOAD_B, 4'd0, 4'd0, 32'h4000_0000);
        push_req(FN_LOAD_B, 4'd1, 4'd0, 32'h7F7F_FFFF);
        push_req(FN_LOAD_B, 4'd2, 4'd0, 32'h0000_0000);
        push_req(FN_LOAD_B, 4'd0, 4'd1, 32'h8080_0000);
        push_req(FN_LOAD_B, 4'd1, 4'd1, 32'h0000_0000);
        push_req(FN_LOAD_B, 4'd2, 4'd1, 32'h3F00_0000);
        push_req(FN_LOAD_A, 4'd15, 4'd15, 32'hFFFF_FFFF);
        push_req(FN_LOAD_B, 4'd15, 4'd8, 32'hFFFF_FFFF);
        push_req(FN_LOAD_A, 4'd8, 4'd0, 32'h0000_0000);
        push_req(FN_NONE, 4'd15, 4'd15, 32'hFFFF_FFFF);
        push_req(FN_RUN, 4'd0, 4'd0, 32'd0);
        push_req(FN_LOAD_A, 4'd0, 4'd0, 32'h8000_0000);
        push_req(FN_LOAD_A, 4'd0, 4'd1, 32'h8000_0000);
        push_req(FN_LOAD_B, 4'd0, 4'd0, 32'h0000_0001);
        push_req(FN_LOAD_B, 4'd1, 4'd0, 32'h0080_0000);
        push_req(FN_LOAD_A, 4'd1, 4'd1, 32'h0000_0001);
        push_req(FN_LOAD_A, 4'd1, 4'd2, 32'h0000_0000);
        push_req(FN_RUN, 4'd15, 4'd15, 32'hFFFF_FFFF);
        drain();

        run_phase(0, 0, 0, 3, 1'b0);
        run_phase(15, 15, 2, 1, 1'b0);
        run_phase(2, 1, 31, 1, 1'b0);
        repeat (4)
        begin
            run_phase($urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 6),
                      3, 1'b0);
        end
        run_phase(2, 2, 2, 5, 1'b1);
        quiet = 1'b1;
        run_phase(3, 3, 4, 4, 1'b0);

        if (errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
design/spmm_pkg.sv
design/spmm_in_if.sv
design/spmm_out_if.sv
design/spmm_cfg_if.sv
design/spmm_ram.sv
design/spmm_cell.sv
design/single_precision_matrix_multiply.sv
bench/single_precision_matrix_multiply_tb.sv
